[design/ata_pkg.sv]
package ata_pkg;

   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 31;

   localparam logic [32:0] HALF_PI_Q30 = 33'd1686629712;
   localparam logic [16:0] DEG_K_HI    = 17'h1CA5D;
   localparam logic [15:0] DEG_K_LO    = 16'hC1A6;
   localparam logic [63:0] DEG_ROUND   = 64'd1 << 49;
   localparam logic [13:0] MAX_MAG     = 14'd11520;

   typedef struct packed {
      logic        neg;
      logic        zero;
      logic [30:0] p;
      logic [61:0] rem;
      logic [62:0] root;
   } sqrt_data_type;

   typedef struct packed {
      logic        neg;
      logic        zero;
      logic [35:0] u;
      logic [35:0] v;
      logic [32:0] w;
   } cordic_data_type;

   // atan(2^-i) in radians, q30, truncated
   function automatic logic [30:0] atan_q30(input logic [4:0] idx);
      logic [30:0] t;
      case (idx)
         5'd0:    t = 31'h3243F6A8;
         5'd1:    t = 31'h1DAC6705;
         5'd2:    t = 31'h0FADBAFC;
         5'd3:    t = 31'h07F56EA6;
         5'd4:    t = 31'h03FEAB76;
         5'd5:    t = 31'h01FFD55B;
         5'd6:    t = 31'h00FFFAAA;
         5'd7:    t = 31'h007FFF55;
         5'd8:    t = 31'h003FFFEA;
         5'd9:    t = 31'h001FFFFD;
         5'd10:   t = 31'h000FFFFF;
         5'd11:   t = 31'h0007FFFF;
         5'd12:   t = 31'h0003FFFF;
         5'd13:   t = 31'h0001FFFF;
         5'd14:   t = 31'h0000FFFF;
         5'd15:   t = 31'h00007FFF;
         5'd16:   t = 31'h00003FFF;
         5'd17:   t = 31'h00001FFF;
         5'd18:   t = 31'h00000FFF;
         5'd19:   t = 31'h000007FF;
         5'd20:   t = 31'h000003FF;
         5'd21:   t = 31'h000001FF;
         5'd22:   t = 31'h000000FF;
         5'd23:   t = 31'h0000007F;
         5'd24:   t = 31'h0000003F;
         5'd25:   t = 31'h0000001F;
         5'd26:   t = 31'h0000000F;
         5'd27:   t = 31'h00000008;
         5'd28:   t = 31'h00000004;
         5'd29:   t = 31'h00000002;
         5'd30:   t = 31'h00000001;
         default: t = 31'h00000000;
      endcase
      return t;
   endfunction

endpackage

[design/ata_front.sv]
module ata_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [15:0]            accel_x,
   input  logic [15:0]            accel_y,
   input  logic [15:0]            accel_z,
   output logic                   out_valid,
   output ata_pkg::sqrt_data_type out_data
);

   function automatic logic [2:0] msb_pos8(input logic [7:0] b);
      logic [2:0] pos;
      pos = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            pos = 3'(i);
         end
      end
      return pos;
   endfunction

   logic [5:0] valid_ff, valid_in;

   logic        neg1_ff;
   logic [16:0] ax_ff, ay_ff, az_ff, ax_in, ay_in, az_in;

   logic        neg2_ff;
   logic [16:0] a2_ff;
   logic [30:0] asq2_ff, ysq2_ff, zsq2_ff;
   logic [33:0] asq_full, ysq_full, zsq_full;

   logic        neg3_ff;
   logic [16:0] a3_ff;
   logic [30:0] asq3_ff;
   logic [31:0] ssq3_ff, ssq3_in;

   logic            neg4_ff;
   logic [16:0]     a4_ff;
   logic [31:0]     ssq4_ff, mx4_in;
   logic [3:0]      nz4_ff, nz4_in;
   logic [3:0][2:0] pos4_ff, pos4_in;

   logic        neg5_ff, zero5_ff, zero5_in;
   logic [16:0] a5_ff;
   logic [31:0] ssq5_ff;
   logic [4:0]  sh5_ff, sh5_in, bitpos;
   logic [5:0]  diff;

   ata_pkg::sqrt_data_type data_ff, data_in;
   logic [46:0]            p_wide;

   assign valid_in = {valid_ff[4:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // absolute values
   always_comb begin
      ax_in = accel_x[15] ? 17'd0 - {accel_x[15], accel_x} : {1'b0, accel_x};
      ay_in = accel_y[15] ? 17'd0 - {accel_y[15], accel_y} : {1'b0, accel_y};
      az_in = accel_z[15] ? 17'd0 - {accel_z[15], accel_z} : {1'b0, accel_z};
   end

   // squares
   assign asq_full = 34'(ax_ff) * 34'(ax_ff);
   assign ysq_full = 34'(ay_ff) * 34'(ay_ff);
   assign zsq_full = 34'(az_ff) * 34'(az_ff);

   assign ssq3_in = {1'b0, ysq2_ff} + {1'b0, zsq2_ff};

   // larger of the two and per-byte leading one
   always_comb begin
      mx4_in = ({1'b0, asq3_ff} > ssq3_ff) ? {1'b0, asq3_ff} : ssq3_ff;
      for (int k = 0; k < 4; k++) begin
         nz4_in[k]  = |mx4_in[8*k +: 8];
         pos4_in[k] = msb_pos8(mx4_in[8*k +: 8]);
      end
   end

   // normalization shift
   always_comb begin
      if (nz4_ff[3]) begin
         bitpos = {2'd3, pos4_ff[3]};
      end else if (nz4_ff[2]) begin
         bitpos = {2'd2, pos4_ff[2]};
      end else if (nz4_ff[1]) begin
         bitpos = {2'd1, pos4_ff[1]};
      end else begin
         bitpos = {2'd0, pos4_ff[0]};
      end
      diff     = 6'd61 - {1'b0, bitpos};
      zero5_in = ~|nz4_ff;
      sh5_in   = zero5_in ? 5'd0 : diff[5:1];
   end

   always_comb begin
      p_wide       = 47'(a5_ff) << sh5_ff;
      data_in.neg  = neg5_ff;
      data_in.zero = zero5_ff;
      data_in.p    = p_wide[30:0];
      data_in.rem  = 62'(ssq5_ff) << {sh5_ff, 1'b0};
      data_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg1_ff <= accel_x[15];
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         az_ff   <= az_in;

         neg2_ff <= neg1_ff;
         a2_ff   <= ax_ff;
         asq2_ff <= asq_full[30:0];
         ysq2_ff <= ysq_full[30:0];
         zsq2_ff <= zsq_full[30:0];

         neg3_ff <= neg2_ff;
         a3_ff   <= a2_ff;
         asq3_ff <= asq2_ff;
         ssq3_ff <= ssq3_in;

         neg4_ff <= neg3_ff;
         a4_ff   <= a3_ff;
         ssq4_ff <= ssq3_ff;
         nz4_ff  <= nz4_in;
         pos4_ff <= pos4_in;

         neg5_ff  <= neg4_ff;
         a5_ff    <= a4_ff;
         ssq5_ff  <= ssq4_ff;
         zero5_ff <= zero5_in;
         sh5_ff   <= sh5_in;

         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_data  = data_ff;

endmodule

[design/ata_sqrt_cell.sv]
module ata_sqrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [4:0]             stage_idx,
   input  logic                   in_valid,
   input  ata_pkg::sqrt_data_type in_data,
   output logic                   out_valid,
   output ata_pkg::sqrt_data_type out_data
);

   logic                   valid_ff;
   ata_pkg::sqrt_data_type data_ff, data_in;
   logic [5:0]             shamt;
   logic [63:0]            bit_w, trial;
   logic [62:0]            root_half;

   always_comb begin
      shamt     = 6'd62 - {stage_idx, 1'b0};
      bit_w     = 64'd1 << shamt;
      trial     = {1'b0, in_data.root} + bit_w;
      root_half = {1'b0, in_data.root[62:1]};
      data_in   = in_data;
      if ({2'b00, in_data.rem} >= trial) begin
         data_in.rem  = in_data.rem - trial[61:0];
         data_in.root = root_half + bit_w[62:0];
      end else begin
         data_in.root = root_half;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[design/ata_cordic_cell.sv]
module ata_cordic_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [4:0]               stage_idx,
   input  logic                     in_valid,
   input  ata_pkg::cordic_data_type in_data,
   output logic                     out_valid,
   output ata_pkg::cordic_data_type out_data
);

   logic                     valid_ff;
   ata_pkg::cordic_data_type data_ff, data_in;
   logic [35:0]              du, dv;
   logic [32:0]              angle;

   always_comb begin
      du      = 36'($signed(in_data.v) >>> stage_idx);
      dv      = 36'($signed(in_data.u) >>> stage_idx);
      angle   = {2'b00, ata_pkg::atan_q30(stage_idx)};
      data_in = in_data;
      if (!in_data.v[35]) begin
         data_in.u = in_data.u + du;
         data_in.v = in_data.v - dv;
         data_in.w = in_data.w + angle;
      end else begin
         data_in.u = in_data.u - du;
         data_in.v = in_data.v + dv;
         data_in.w = in_data.w - angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[design/ata_back.sv]
module ata_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  ata_pkg::cordic_data_type in_data,
   output logic                     out_valid,
   output logic [14:0]              tilt_angle
);

   logic [3:0]  valid_ff;
   logic [3:1]  neg_ff, zero_ff;
   logic [30:0] wc_ff, wc_in;
   logic [46:0] plo_ff;
   logic [47:0] phi_ff;
   logic [63:0] prod;
   logic [13:0] mag_ff, mag_c;
   logic [14:0] tilt_ff, tilt_in;

   // clamp to 0..pi/2
   always_comb begin
      if (in_data.w[32]) begin
         wc_in = '0;
      end else if (in_data.w > ata_pkg::HALF_PI_Q30) begin
         wc_in = ata_pkg::HALF_PI_Q30[30:0];
      end else begin
         wc_in = in_data.w[30:0];
      end
   end

   assign prod = {phi_ff, 16'h0000} + {17'd0, plo_ff} + ata_pkg::DEG_ROUND;

   always_comb begin
      mag_c = (mag_ff > ata_pkg::MAX_MAG) ? ata_pkg::MAX_MAG : mag_ff;
      if (zero_ff[3]) begin
         mag_c = '0;
      end
      tilt_in = neg_ff[3] ? 15'd0 - {1'b0, mag_c} : {1'b0, mag_c};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_ff  <= {neg_ff[2:1], in_data.neg};
         zero_ff <= {zero_ff[2:1], in_data.zero};
         wc_ff   <= wc_in;
         plo_ff  <= 47'(wc_ff) * 47'(ata_pkg::DEG_K_LO);
         phi_ff  <= 48'(wc_ff) * 48'(ata_pkg::DEG_K_HI);
         mag_ff  <= prod[63:50];
         tilt_ff <= tilt_in;
      end
   end

   assign out_valid  = valid_ff[3];
   assign tilt_angle = tilt_ff;

endmodule

[design/accel_tilt_angle_top.sv]
// accelerometer tilt angle, atan2(x, sqrt(y*y + z*z)) in 1/128 degree
//
// req channel: one sample per request, tdata holds accel_x, accel_y, accel_z
// as signed 16-bit values. rsp channel: one signed 15-bit tilt_angle per
// request, in the range -11520..11520 (-90..+90 degrees), rounded to nearest.
// an all-zero sample gives 0.
//
// throughput: one request per cycle while req_tready is high. stages from
// acceptance to rsp_tvalid: 6 front stages (abs, squares, sum,
// leading-one search, shift select, normalize), 32 square-root cells,
// 31 cordic cells, 4 back stages (clamp, multiply, round, sign) and the
// output register.
//
// reset clears every stage valid and the output and skid valids; the pipe comes up empty.
// when rsp_tready is low the result waits in the output register and one
// more result is caught in a skid register; once that one is full the
// pipeline holds and req_tready goes low until the receiver takes a result.
module accel_tilt_angle_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // accel_x, accel_y, accel_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // tilt_angle, one zero pad bit
);

   logic advance;

   logic                     sq_valid [0:ata_pkg::SQRT_STEPS];
   ata_pkg::sqrt_data_type   sq_data  [0:ata_pkg::SQRT_STEPS];
   logic                     cd_valid [0:ata_pkg::CORDIC_STEPS];
   ata_pkg::cordic_data_type cd_data  [0:ata_pkg::CORDIC_STEPS];

   logic        bk_valid;
   logic [14:0] bk_tilt;

   logic        push, pop;
   logic        rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   logic [14:0] rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;

   assign advance    = ~skid_valid_ff;
   assign req_tready = advance;

   ata_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .accel_x   (req_tdata[15:0]),
      .accel_y   (req_tdata[31:16]),
      .accel_z   (req_tdata[47:32]),
      .out_valid (sq_valid[0]),
      .out_data  (sq_data[0])
   );

   for (genvar g = 0; g < ata_pkg::SQRT_STEPS; g++) begin : g_sqrt
      ata_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (5'(g)),
         .in_valid  (sq_valid[g]),
         .in_data   (sq_data[g]),
         .out_valid (sq_valid[g+1]),
         .out_data  (sq_data[g+1])
      );
   end

   always_comb begin
      cd_valid[0]     = sq_valid[ata_pkg::SQRT_STEPS];
      cd_data[0].neg  = sq_data[ata_pkg::SQRT_STEPS].neg;
      cd_data[0].zero = sq_data[ata_pkg::SQRT_STEPS].zero;
      cd_data[0].u    = {5'd0, sq_data[ata_pkg::SQRT_STEPS].root[30:0]};
      cd_data[0].v    = {5'd0, sq_data[ata_pkg::SQRT_STEPS].p};
      cd_data[0].w    = '0;
   end

   for (genvar g = 0; g < ata_pkg::CORDIC_STEPS; g++) begin : g_cordic
      ata_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (5'(g)),
         .in_valid  (cd_valid[g]),
         .in_data   (cd_data[g]),
         .out_valid (cd_valid[g+1]),
         .out_data  (cd_data[g+1])
      );
   end

   ata_back u_back (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (cd_valid[ata_pkg::CORDIC_STEPS]),
      .in_data    (cd_data[ata_pkg::CORDIC_STEPS]),
      .out_valid  (bk_valid),
      .tilt_angle (bk_tilt)
   );

   // output register with one skid entry
   assign push = advance & bk_valid;
   assign pop  = rsp_valid_ff & rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff) begin
         rsp_valid_in = push;
         rsp_data_in  = bk_tilt;
      end else if (pop) begin
         if (skid_valid_ff) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = push;
            rsp_data_in  = bk_tilt;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = bk_tilt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

[design/ata_checker.sv]
module ata_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic signed [14:0] angle;
   logic               req_seen;

   assign angle    = $signed(rsp_tdata[14:0]);
   assign req_seen = req_tvalid & (|req_tdata | ~|req_tdata);

   // results never appear right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // intake stops only after the receiver has held off a result
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("req_tready dropped without an output stall");

   // angle stays within plus or minus 90 degrees, pad bit clear
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[15] && angle <= 15'sd11520 && angle >= -15'sd11520)
      else $error("tilt angle out of range");

   // intake never stalls while the output side is free
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      req_seen && !rsp_tvalid |-> req_tready)
      else $error("request held off with empty output");

endmodule

bind accel_tilt_angle_top ata_checker u_ata_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
